// ===== rtl/core/ialu_pkg.sv =====
package ialu_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DATA_WIDTH);

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   typedef enum logic [3:0] {
      FN_ADD = 4'd0,
      FN_SUB = 4'd1,
      FN_MUL = 4'd2,
      FN_DIV = 4'd3,
      FN_POW = 4'd4,
      FN_XOR = 4'd5,
      FN_AND = 4'd6,
      FN_OR  = 4'd7,
      FN_INC = 4'd8,
      FN_DEC = 4'd9,
      FN_ABS = 4'd10,
      FN_NOT = 4'd11
   } func_type;

   typedef enum logic [2:0] {
      SRC_ALU = 3'b001,
      SRC_MUL = 3'b010,
      SRC_DIV = 3'b100
   } src_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic word_type magnitude(input word_type x);
      magnitude = x[DATA_WIDTH-1] ? (~x + word_type'(1)) : x;
   endfunction

endpackage

// ===== rtl/core/ialu_mul.sv =====
module ialu_mul (
   input  logic               clock,
   input  logic               en,
   input  ialu_pkg::word_type op_a,
   input  ialu_pkg::word_type op_b,
   output ialu_pkg::word_type product_ff
);

   logic [2*ialu_pkg::DATA_WIDTH-1:0] full;
   ialu_pkg::word_type                product_in;

   assign full       = {{ialu_pkg::DATA_WIDTH{1'b0}}, op_a} *
                       {{ialu_pkg::DATA_WIDTH{1'b0}}, op_b};
   assign product_in = full[ialu_pkg::DATA_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         product_ff <= product_in;
      end
   end

endmodule

// ===== rtl/core/ialu_div.sv =====
module ialu_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  ialu_pkg::word_type       dividend,
   input  ialu_pkg::word_type       divisor,
   output ialu_pkg::div_status_type status,
   output ialu_pkg::word_type       quotient
);

   localparam int W = ialu_pkg::DATA_WIDTH;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               neg_ff, neg_in;
   ialu_pkg::cnt_type  cnt_ff, cnt_in;
   logic [W:0]         rem_ff, rem_in;
   ialu_pkg::word_type quo_ff, quo_in;
   ialu_pkg::word_type den_ff, den_in;
   logic [W:0]         trial;

   // one restoring step: shift in the next dividend bit, try the subtract
   assign trial = {rem_ff[W-1:0], quo_ff[W-1]} - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[W-1] ^ divisor[W-1];
         cnt_in  = ialu_pkg::cnt_type'(W - 1);
         rem_in  = '0;
         quo_in  = ialu_pkg::magnitude(dividend);
         den_in  = ialu_pkg::magnitude(divisor);
      end else if (busy_ff) begin
         rem_in = trial[W] ? {rem_ff[W-1:0], quo_ff[W-1]} : trial;
         quo_in = {quo_ff[W-2:0], ~trial[W]};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - ialu_pkg::cnt_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = neg_ff ? (~quo_ff + ialu_pkg::word_type'(1)) : quo_ff;

endmodule

// ===== rtl/core/integer_alu_with_div_and_power.sv =====
// Add, sub, logic, inc, dec, abs, not, mul, zero-divisor div and pow with a zero or
// negative exponent go straight to the done state; div runs one radix-2 step per cycle
// in the divider; pow squares per exponent bit and also multiplies by the base per set bit,
// one multiply per cycle on the shared multiplier.
// One word in flight; req_stall is high until the result is registered.
// Synchronous active-high reset clears the sequencer and the response valid.
module integer_alu_with_div_and_power (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [3:0]                            req_func,
   input  logic signed [ialu_pkg::DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [ialu_pkg::DATA_WIDTH-1:0] req_operand_b,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ialu_pkg::DATA_WIDTH-1:0] rsp_result,
   output logic                                  rsp_div_by_zero
);

   localparam int W = ialu_pkg::DATA_WIDTH;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_DIV     = 5'b00010,
      ST_POW_SQ  = 5'b00100,
      ST_POW_MUL = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   ialu_pkg::src_type        src_ff, src_in;
   ialu_pkg::word_type       res_ff, res_in;
   logic                     dz_ff, dz_in;
   ialu_pkg::word_type       base_ff, base_in;
   ialu_pkg::word_type       exp_ff, exp_in;
   ialu_pkg::cnt_type        cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ialu_pkg::word_type       rsp_result_ff, rsp_result_in;
   logic                     rsp_dz_ff, rsp_dz_in;

   logic                     accept;
   logic                     rsp_load;
   ialu_pkg::word_type       a, b;
   ialu_pkg::word_type       alu_val;
   ialu_pkg::word_type       done_val;

   logic                     mul_en;
   ialu_pkg::word_type       mul_a, mul_b, product;
   logic                     div_start;
   ialu_pkg::div_status_type div_status;
   ialu_pkg::word_type       quotient;

   assign a        = ialu_pkg::word_type'(req_operand_a);
   assign b        = ialu_pkg::word_type'(req_operand_b);
   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   ialu_mul u_mul (
      .clock      (clock),
      .en         (mul_en),
      .op_a       (mul_a),
      .op_b       (mul_b),
      .product_ff (product)
   );

   ialu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a),
      .divisor  (b),
      .status   (div_status),
      .quotient (quotient)
   );

   always_comb begin
      unique case (ialu_pkg::func_type'(req_func))
         ialu_pkg::FN_ADD: alu_val = a + b;
         ialu_pkg::FN_SUB: alu_val = a - b;
         ialu_pkg::FN_XOR: alu_val = a ^ b;
         ialu_pkg::FN_AND: alu_val = a & b;
         ialu_pkg::FN_OR:  alu_val = a | b;
         ialu_pkg::FN_INC: alu_val = a + ialu_pkg::word_type'(1);
         ialu_pkg::FN_DEC: alu_val = a - ialu_pkg::word_type'(1);
         ialu_pkg::FN_ABS: alu_val = ialu_pkg::magnitude(a);
         ialu_pkg::FN_NOT: alu_val = ~a;
         default:          alu_val = '0;
      endcase
   end

   always_comb begin
      unique case (src_ff)
         ialu_pkg::SRC_MUL: done_val = product;
         ialu_pkg::SRC_DIV: done_val = quotient;
         default:           done_val = res_ff;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      src_in    = src_ff;
      res_in    = res_ff;
      dz_in     = dz_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      cnt_in    = cnt_ff;
      mul_en    = 1'b0;
      mul_a     = a;
      mul_b     = b;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               src_in   = ialu_pkg::SRC_ALU;
               res_in   = alu_val;
               dz_in    = 1'b0;
               state_in = ST_DONE;
               if (ialu_pkg::func_type'(req_func) == ialu_pkg::FN_MUL) begin
                  mul_en = 1'b1;
                  src_in = ialu_pkg::SRC_MUL;
               end else if (ialu_pkg::func_type'(req_func) == ialu_pkg::FN_DIV) begin
                  if (b == '0) begin
                     res_in = '0;
                     dz_in  = 1'b1;
                  end else begin
                     div_start = 1'b1;
                     src_in    = ialu_pkg::SRC_DIV;
                     state_in  = ST_DIV;
                  end
               end else if (ialu_pkg::func_type'(req_func) == ialu_pkg::FN_POW) begin
                  if (b[W-1] || (b == '0)) begin
                     res_in = ialu_pkg::word_type'(1);
                  end else begin
                     // seed the accumulator with one
                     mul_en   = 1'b1;
                     mul_a    = ialu_pkg::word_type'(1);
                     mul_b    = ialu_pkg::word_type'(1);
                     base_in  = a;
                     exp_in   = b;
                     cnt_in   = ialu_pkg::cnt_type'(W - 1);
                     src_in   = ialu_pkg::SRC_MUL;
                     state_in = ST_POW_SQ;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_DONE;
            end
         end
         ST_POW_SQ: begin
            mul_en = 1'b1;
            mul_a  = product;
            mul_b  = product;
            if (exp_ff[W-1]) begin
               state_in = ST_POW_MUL;
            end else if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - ialu_pkg::cnt_type'(1);
               exp_in = {exp_ff[W-2:0], 1'b0};
            end
         end
         ST_POW_MUL: begin
            mul_en = 1'b1;
            mul_a  = product;
            mul_b  = base_ff;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff - ialu_pkg::cnt_type'(1);
               exp_in   = {exp_ff[W-2:0], 1'b0};
               state_in = ST_POW_SQ;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_dz_in     = rsp_dz_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = done_val;
         rsp_dz_in     = dz_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff        <= src_in;
      res_ff        <= res_in;
      dz_ff         <= dz_in;
      base_ff       <= base_in;
      exp_ff        <= exp_in;
      cnt_ff        <= cnt_in;
      rsp_result_ff <= rsp_result_in;
      rsp_dz_ff     <= rsp_dz_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result      = $signed(rsp_result_ff);
   assign rsp_div_by_zero = rsp_dz_ff;

endmodule

// ===== test/tb_integer_alu_with_div_and_power.sv =====
`timescale 1ns / 1ps

module tb_integer_alu_with_div_and_power;

   localparam int DATA_WIDTH = ialu_pkg::DATA_WIDTH;

   typedef ialu_pkg::word_type word_type;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 2 * DATA_WIDTH + 8;
   localparam int          PHASE_WORDS  = 200;
   localparam logic [3:0]  FN_SPARE_LO  = 4'd12;
   localparam logic [3:0]  FN_SPARE_HI  = 4'd15;
   localparam word_type    WORD_MIN     = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam word_type    WORD_MAX     = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam word_type    WORD_ONES    = {DATA_WIDTH{1'b1}};

   typedef struct {
      logic [3:0] func;
      word_type   a;
      word_type   b;
   } alu_word_type;

   typedef struct {
      logic [3:0] func;
      word_type   result;
      logic       div_by_zero;
   } alu_outcome_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [3:0] req_func;
   logic signed [DATA_WIDTH-1:0] req_operand_a;
   logic signed [DATA_WIDTH-1:0] req_operand_b;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [DATA_WIDTH-1:0] rsp_result;
   logic rsp_div_by_zero;

   alu_word_type    req_words[$];
   alu_outcome_type results_due[$];

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int words_checked;
   int div_zero_seen;
   int cycle_count;
   logic [15:0] codes_sent;

   integer_alu_with_div_and_power dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

   always #4 clock = ~clock;

   function automatic word_type abs_wrap(word_type x);
      return x[DATA_WIDTH-1] ? word_type'(-x) : x;
   endfunction

   function automatic word_type quotient_trunc(word_type a, word_type b);
      word_type q;
      q = abs_wrap(a) / abs_wrap(b);
      if (a[DATA_WIDTH-1] != b[DATA_WIDTH-1]) begin
         q = -q;
      end
      return q;
   endfunction

   function automatic word_type power_wrap(word_type base, word_type ex);
      word_type acc;
      acc = word_type'(1);
      if (ex[DATA_WIDTH-1] || ex == '0) begin
         return acc;
      end
      for (int i = DATA_WIDTH - 1; i >= 0; i--) begin
         acc = acc * acc;
         if (ex[i]) begin
            acc = acc * base;
         end
      end
      return acc;
   endfunction

   function automatic alu_outcome_type alu_compute(alu_word_type w);
      alu_outcome_type o;
      o.func        = w.func;
      o.result      = '0;
      o.div_by_zero = 1'b0;
      case (w.func)
         ialu_pkg::FN_ADD: o.result = w.a + w.b;
         ialu_pkg::FN_SUB: o.result = w.a - w.b;
         ialu_pkg::FN_MUL: o.result = w.a * w.b;
         ialu_pkg::FN_DIV: begin
            if (w.b == '0) begin
               o.div_by_zero = 1'b1;
            end else begin
               o.result = quotient_trunc(w.a, w.b);
            end
         end
         ialu_pkg::FN_POW: o.result = power_wrap(w.a, w.b);
         ialu_pkg::FN_XOR: o.result = w.a ^ w.b;
         ialu_pkg::FN_AND: o.result = w.a & w.b;
         ialu_pkg::FN_OR:  o.result = w.a | w.b;
         ialu_pkg::FN_INC: o.result = w.a + word_type'(1);
         ialu_pkg::FN_DEC: o.result = w.a - word_type'(1);
         ialu_pkg::FN_ABS: o.result = abs_wrap(w.a);
         ialu_pkg::FN_NOT: o.result = ~w.a;
         default: o.result = '0;
      endcase
      return o;
   endfunction

   function automatic word_type pick_operand();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return word_type'(1);
               2: return WORD_ONES;
               3: return WORD_MIN;
               default: return WORD_MAX;
            endcase
         end
         1, 2: return word_type'($urandom_range(0, 32)) - word_type'(16);
         default: return word_type'($urandom);
      endcase
   endfunction

   task automatic queue_word(logic [3:0] func, word_type a, word_type b);
      alu_word_type w;
      w.func = func;
      w.a    = a;
      w.b    = b;
      req_words.push_back(w);
   endtask

   task automatic queue_random(int count);
      logic [3:0] func;
      word_type   a;
      word_type   b;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            func = 4'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
         end else begin
            func = 4'($urandom_range(ialu_pkg::FN_ADD, ialu_pkg::FN_NOT));
         end
         a = pick_operand();
         b = pick_operand();
         // keep most exponents small so power stays readable, still hit large ones
         if (func == ialu_pkg::FN_POW && $urandom_range(0, 3) != 0) begin
            b = word_type'($urandom_range(0, 40)) - word_type'(4);
         end
         queue_word(func, a, b);
      end
   endtask

   task automatic wait_drained();
      while (req_words.size() != 0 || req_valid || results_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // driver: hold the word until accepted, then advance or idle
   always @(posedge clock) begin : drive_req
      alu_word_type w;
      logic         fire;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && !req_stall;
         if (fire) begin
            w.func = req_func;
            w.a    = req_operand_a;
            w.b    = req_operand_b;
            results_due.push_back(alu_compute(w));
            codes_sent[req_func] = 1'b1;
         end
         if (fire || !req_valid) begin
            if (req_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               w = req_words.pop_front();
               req_valid     <= 1'b1;
               req_func      <= w.func;
               req_operand_a <= w.a;
               req_operand_b <= w.b;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each accepted result word against the oldest prediction
   always @(posedge clock) begin : watch_rsp
      alu_outcome_type exp_o;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $error("result word with no prediction pending: result %h", rsp_result);
               error_count++;
            end else begin
               exp_o = results_due.pop_front();
               words_checked++;
               if (rsp_div_by_zero) begin
                  div_zero_seen++;
               end
               if (rsp_result !== exp_o.result) begin
                  $error("result mismatch (func %0d): expected %h actual %h",
                         exp_o.func, exp_o.result, rsp_result);
                  error_count++;
               end
               if (rsp_div_by_zero !== exp_o.div_by_zero) begin
                  $error("div_by_zero mismatch (func %0d): expected %b actual %b",
                         exp_o.func, exp_o.div_by_zero, rsp_div_by_zero);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = '0;
      req_operand_a = '0;
      req_operand_b = '0;
      rsp_stall     = 1'b0;
      send_idle_pct = 21;
      recv_idle_pct = 55;
      error_count   = 0;
      words_checked = 0;
      div_zero_seen = 0;
      cycle_count   = 0;
      codes_sent    = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      queue_word(ialu_pkg::FN_ADD, WORD_MAX, word_type'(1));
      queue_word(ialu_pkg::FN_SUB, WORD_MIN, word_type'(1));
      queue_word(ialu_pkg::FN_MUL, WORD_MAX, WORD_MAX);
      queue_word(ialu_pkg::FN_MUL, WORD_MIN, WORD_ONES);
      queue_word(ialu_pkg::FN_DIV, word_type'(1234), '0);
      queue_word(ialu_pkg::FN_DIV, WORD_MIN, WORD_ONES);
      queue_word(ialu_pkg::FN_DIV, word_type'(-7), word_type'(2));
      queue_word(ialu_pkg::FN_DIV, WORD_MAX, WORD_MIN);
      queue_word(ialu_pkg::FN_POW, word_type'(7), '0);
      queue_word(ialu_pkg::FN_POW, word_type'(3), word_type'(-2));
      queue_word(ialu_pkg::FN_POW, word_type'(3), word_type'(5));
      queue_word(ialu_pkg::FN_POW, word_type'(2), word_type'(31));
      queue_word(ialu_pkg::FN_POW, WORD_ONES, WORD_MAX);
      queue_word(ialu_pkg::FN_XOR, WORD_ONES, word_type'(32'h5a5a_a5a5));
      queue_word(ialu_pkg::FN_AND, WORD_ONES, WORD_MIN);
      queue_word(ialu_pkg::FN_OR,  '0, WORD_ONES);
      queue_word(ialu_pkg::FN_INC, WORD_MAX, WORD_ONES);
      queue_word(ialu_pkg::FN_DEC, WORD_MIN, WORD_ONES);
      queue_word(ialu_pkg::FN_ABS, WORD_MIN, '0);
      queue_word(ialu_pkg::FN_ABS, word_type'(-5), WORD_ONES);
      queue_word(ialu_pkg::FN_NOT, '0, WORD_ONES);
      for (int c = FN_SPARE_LO; c <= FN_SPARE_HI; c++) begin
         queue_word(4'(c), WORD_ONES, WORD_ONES);
      end

      queue_random(PHASE_WORDS);
      wait_drained();

      send_idle_pct = 55;
      recv_idle_pct = 21;
      queue_random(PHASE_WORDS);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(PHASE_WORDS);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (results_due.size() != 0) begin
         $error("%0d predicted result words never arrived", results_due.size());
         error_count++;
      end

      $display("Checked %0d result words (%0d flagged divide by zero), %0d of 16 func codes",
               words_checked, div_zero_seen, $countones(codes_sent));
      $display("Idle mix: sender-light, receiver-light, then back-to-back traffic");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
